/* sv/spcp_pkg.sv */
// Shared constants for the segment pair closest points block.
`timescale 1ns / 1ps

package spcp_pkg;

  localparam int MUL_DIGIT_BITS = 8;
  localparam int AXES = 3;
  localparam int IN_FIELDS = 12;

endpackage

/* sv/spcp_mul.sv */
// Pipelined signed multiplier lanes, one multiplier digit per stage, with side payload.
`timescale 1ns / 1ps

module spcp_mul #(
  parameter int N  = 1,
  parameter int WA = 8,
  parameter int WB = 8,
  parameter int WS = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    vin,
  input  logic signed [WA-1:0]    a [N],
  input  logic signed [WB-1:0]    b [N],
  input  logic [WS-1:0]           side_in,
  output logic                    vout,
  output logic signed [WA+WB-1:0] p [N],
  output logic [WS-1:0]           side_out
);

  localparam int D  = spcp_pkg::MUL_DIGIT_BITS;
  localparam int L  = (WB + D - 1) / D;
  localparam int BP = D * L;
  localparam int PW = WA + BP;

  logic [L-1:0]          v;
  logic [WS-1:0]         sd  [L];
  logic signed [WA-1:0]  ar  [L][N];
  logic signed [BP-1:0]  br  [L][N];
  logic signed [PW-1:0]  acc [L][N];

  for (genvar j = 0; j < L; j++) begin : g_step
    logic          v_j;
    logic [WS-1:0] side_j;

    if (j == 0) begin : g_src
      assign v_j    = vin;
      assign side_j = side_in;
    end else begin : g_src
      assign v_j    = v[j-1];
      assign side_j = sd[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= v_j;
      end
      if (en) begin
        sd[j] <= side_j;
      end
    end

    for (genvar i = 0; i < N; i++) begin : g_lane
      logic signed [WA-1:0]  ai;
      logic signed [BP-1:0]  bi;
      logic signed [PW-1:0]  ci;
      logic signed [D:0]     dig;
      logic signed [WA+D:0]  part;

      if (j == 0) begin : g_in
        assign ai = a[i];
        assign bi = BP'(b[i]);
        assign ci = '0;
      end else begin : g_in
        assign ai = ar[j-1][i];
        assign bi = br[j-1][i];
        assign ci = acc[j-1][i];
      end

      if (j == L - 1) begin : g_dig
        assign dig = $signed({bi[D*j+D-1], bi[D*j +: D]});
      end else begin : g_dig
        assign dig = $signed({1'b0, bi[D*j +: D]});
      end

      assign part = ai * dig;

      always_ff @(posedge clk) begin
        if (en) begin
          ar[j][i]  <= ai;
          br[j][i]  <= bi;
          acc[j][i] <= ci + (PW'(part) <<< (D * j));
        end
      end
    end
  end

  assign vout     = v[L-1];
  assign side_out = sd[L-1];

  for (genvar i = 0; i < N; i++) begin : g_out
    assign p[i] = acc[L-1][i][WA+WB-1:0];
  end

endmodule

/* sv/segment_pair_closest_points.sv */
// Top level: closest points and gap between two 3D segments, fully pipelined.
//
//  channel  | direction | handshake        | payload
//  s_*      | in        | s_tvalid/tready  | twelve signed coordinates
//  m_*      | out       | m_tvalid/tready  | gap_distance, first_param, second_param
//
// One pair enters per cycle while m_tready does not hold the pipeline. The pipeline includes the
// multiplier digit stages, the PARAM_FRAC_BITS divider steps and one stage per root bit of the square root.
// Reset clears the valid bits only; there is no clearing pass.
// The whole pipeline holds while a result waits and m_tready is low.
`timescale 1ns / 1ps

module segment_pair_closest_points #(
  parameter int COORD_WIDTH     = 24,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // first_start_x/y/z, first_end_x/y/z, second_start_x/y/z, second_end_x/y/z
  input  logic [((spcp_pkg::IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // gap_distance, first_param, second_param
  output logic [((COORD_WIDTH+1+2*(PARAM_FRAC_BITS+1)+7)/8)*8-1:0] m_tdata
);

  localparam int CW  = COORD_WIDTH;
  localparam int P   = PARAM_FRAC_BITS;
  localparam int NA  = spcp_pkg::AXES;
  localparam int DW  = CW + 1;
  localparam int QW  = 2 * DW + 2;
  localparam int NW  = 2 * QW + 1;
  localparam int TW  = QW + NW + 1;
  localparam int RW  = TW + 1;
  localparam int PO  = P + 1;
  localparam int SWB = P + 2;
  localparam int WW  = DW + P + 3;
  localparam int SW  = 2 * WW + 2;
  localparam int RB  = SW / 2;
  localparam int GW  = CW + 1;
  localparam int OW  = ((GW + 2 * PO + 7) / 8) * 8;
  localparam logic [PO-1:0] ONE = PO'(1) << P;

  typedef struct packed {
    logic [NA-1:0][DW-1:0] d1;
    logic [NA-1:0][DW-1:0] d2;
    logic [NA-1:0][DW-1:0] r;
  } geo_t;

  typedef struct packed {
    geo_t          g;
    logic [QW-1:0] a;
    logic [QW-1:0] b;
    logic [QW-1:0] c;
    logic [QW-1:0] e;
    logic [QW-1:0] f;
  } dots_t;

  typedef struct packed {
    dots_t         q;
    logic [NW-1:0] sn;
    logic [NW-1:0] sd;
  } sel_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] den;
    logic [P-1:0]  q;
    logic          zero;
    logic          one;
  } div_t;

  typedef struct packed {
    logic [NA-1:0][DW-1:0] r;
    logic [PO-1:0]         sq;
    logic [PO-1:0]         tq;
  } fin_t;

  typedef struct packed {
    logic [PO-1:0] sq;
    logic [PO-1:0] tq;
  } par_t;

  typedef struct packed {
    logic [SW-1:0]   rad;
    logic [RB+1:0]   rem;
    logic [RB-1:0]   root;
  } sqr_t;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // differences
  logic v1;
  geo_t g1;
  geo_t g1_next;

  always_comb begin
    g1_next = '0;
    for (int k = 0; k < NA; k++) begin
      g1_next.d1[k] = DW'($signed(s_tdata[(3+k)*CW +: CW])) - DW'($signed(s_tdata[k*CW +: CW]));
      g1_next.d2[k] = DW'($signed(s_tdata[(9+k)*CW +: CW]))
                    - DW'($signed(s_tdata[(6+k)*CW +: CW]));
      g1_next.r[k]  = DW'($signed(s_tdata[k*CW +: CW])) - DW'($signed(s_tdata[(6+k)*CW +: CW]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
    if (en) begin
      g1 <= g1_next;
    end
  end

  // dot products
  logic signed [DW-1:0]   m1_a [15];
  logic signed [DW-1:0]   m1_b [15];
  logic signed [2*DW-1:0] m1_p [15];
  logic                   m1_v;
  geo_t                   m1_g;

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      m1_a[k]    = $signed(g1.d1[k]);  m1_b[k]    = $signed(g1.d1[k]);
      m1_a[3+k]  = $signed(g1.d2[k]);  m1_b[3+k]  = $signed(g1.d2[k]);
      m1_a[6+k]  = $signed(g1.d1[k]);  m1_b[6+k]  = $signed(g1.d2[k]);
      m1_a[9+k]  = $signed(g1.d1[k]);  m1_b[9+k]  = $signed(g1.r[k]);
      m1_a[12+k] = $signed(g1.d2[k]);  m1_b[12+k] = $signed(g1.r[k]);
    end
  end

  spcp_mul #(.N(15), .WA(DW), .WB(DW), .WS($bits(geo_t))) u_mul_dot (
    .clk(clk), .rst(rst), .en(en), .vin(v1), .a(m1_a), .b(m1_b), .side_in(g1),
    .vout(m1_v), .p(m1_p), .side_out(m1_g)
  );

  logic  v2;
  dots_t q2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= m1_v;
    end
    if (en) begin
      q2.g <= m1_g;
      q2.a <= QW'(m1_p[0])  + QW'(m1_p[1])  + QW'(m1_p[2]);
      q2.e <= QW'(m1_p[3])  + QW'(m1_p[4])  + QW'(m1_p[5]);
      q2.b <= QW'(m1_p[6])  + QW'(m1_p[7])  + QW'(m1_p[8]);
      q2.c <= QW'(m1_p[9])  + QW'(m1_p[10]) + QW'(m1_p[11]);
      q2.f <= QW'(m1_p[12]) + QW'(m1_p[13]) + QW'(m1_p[14]);
    end
  end

  // cross products of the dot terms
  logic signed [QW-1:0]   m2_a [4];
  logic signed [QW-1:0]   m2_b [4];
  logic signed [2*QW-1:0] m2_p [4];
  logic                   m2_v;
  dots_t                  m2_q;

  assign m2_a[0] = $signed(q2.a);  assign m2_b[0] = $signed(q2.e);
  assign m2_a[1] = $signed(q2.b);  assign m2_b[1] = $signed(q2.b);
  assign m2_a[2] = $signed(q2.b);  assign m2_b[2] = $signed(q2.f);
  assign m2_a[3] = $signed(q2.c);  assign m2_b[3] = $signed(q2.e);

  spcp_mul #(.N(4), .WA(QW), .WB(QW), .WS($bits(dots_t))) u_mul_cross (
    .clk(clk), .rst(rst), .en(en), .vin(v2), .a(m2_a), .b(m2_b), .side_in(q2),
    .vout(m2_v), .p(m2_p), .side_out(m2_q)
  );

  logic          v3;
  dots_t         q3;
  logic [NW-1:0] den3;
  logic [NW-1:0] num3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= m2_v;
    end
    if (en) begin
      q3   <= m2_q;
      den3 <= NW'(m2_p[0]) - NW'(m2_p[1]);
      num3 <= NW'(m2_p[2]) - NW'(m2_p[3]);
    end
  end

  // starting s as a ratio sn/sd
  logic v4;
  sel_t s4;
  sel_t s4_next;
  logic dnz;
  logic npos;
  logic nlt;

  always_comb begin
    dnz  = den3 != '0;
    npos = !num3[NW-1] && (num3 != '0);
    nlt  = $signed(num3) < $signed(den3);
    s4_next    = '0;
    s4_next.q  = q3;
    s4_next.sn = '0;
    s4_next.sd = NW'(1);
    priority if (dnz && npos && nlt) begin
      s4_next.sn = num3;
      s4_next.sd = den3;
    end else if (dnz && npos) begin
      s4_next.sn = NW'(1);
    end else begin
      s4_next.sn = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      s4 <= s4_next;
    end
  end

  // t numerator and denominator
  logic signed [QW-1:0]    m3_a [3];
  logic signed [NW-1:0]    m3_b [3];
  logic signed [QW+NW-1:0] m3_p [3];
  logic                    m3_v;
  sel_t                    m3_s;

  assign m3_a[0] = $signed(s4.q.b);  assign m3_b[0] = $signed(s4.sn);
  assign m3_a[1] = $signed(s4.q.f);  assign m3_b[1] = $signed(s4.sd);
  assign m3_a[2] = $signed(s4.q.e);  assign m3_b[2] = $signed(s4.sd);

  spcp_mul #(.N(3), .WA(QW), .WB(NW), .WS($bits(sel_t))) u_mul_t (
    .clk(clk), .rst(rst), .en(en), .vin(v4), .a(m3_a), .b(m3_b), .side_in(s4),
    .vout(m3_v), .p(m3_p), .side_out(m3_s)
  );

  logic          v5;
  sel_t          s5;
  logic [TW-1:0] tn5;
  logic [TW-1:0] td5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= m3_v;
    end
    if (en) begin
      s5  <= m3_s;
      tn5 <= TW'(m3_p[0]) + TW'(m3_p[1]);
      td5 <= TW'(m3_p[2]);
    end
  end

  // pick the two ratios to divide
  logic          v6;
  geo_t          g6;
  logic [TW-1:0] sn6;
  logic [TW-1:0] sd6;
  logic [TW-1:0] tn6;
  logic [TW-1:0] td6;
  logic [TW-1:0] sn_next;
  logic [TW-1:0] sd_next;
  logic [TW-1:0] tn_next;
  logic [TW-1:0] td_next;
  logic [TW-1:0] negc;
  logic [TW-1:0] bmc;
  logic          az;
  logic          ez;

  always_comb begin
    az      = s5.q.a == '0;
    ez      = s5.q.e == '0;
    negc    = -TW'($signed(s5.q.c));
    bmc     = TW'($signed(s5.q.b)) - TW'($signed(s5.q.c));
    sn_next = '0;
    sd_next = TW'(1);
    tn_next = '0;
    td_next = TW'(1);
    priority if (az && ez) begin
      sn_next = '0;
    end else if (az) begin
      tn_next = TW'($signed(s5.q.f));
      td_next = TW'($signed(s5.q.e));
    end else if (ez) begin
      sn_next = negc;
      sd_next = TW'($signed(s5.q.a));
    end else if (tn5[TW-1]) begin
      sn_next = negc;
      sd_next = TW'($signed(s5.q.a));
    end else if ($signed(td5) < $signed(tn5)) begin
      tn_next = TW'(1);
      sn_next = bmc;
      sd_next = TW'($signed(s5.q.a));
    end else begin
      tn_next = tn5;
      td_next = td5;
      sn_next = TW'($signed(s5.sn));
      sd_next = TW'($signed(s5.sd));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      g6  <= s5.q.g;
      sn6 <= sn_next;
      sd6 <= sd_next;
      tn6 <= tn_next;
      td6 <= td_next;
    end
  end

  // clamp checks before the divide
  logic v7;
  geo_t g7;
  div_t ds7;
  div_t dt7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
    if (en) begin
      g7       <= g6;
      ds7.rem  <= RW'(sn6);
      ds7.den  <= RW'(sd6);
      ds7.q    <= '0;
      ds7.zero <= sn6[TW-1] || (sn6 == '0);
      ds7.one  <= !($signed(sn6) < $signed(sd6));
      dt7.rem  <= RW'(tn6);
      dt7.den  <= RW'(td6);
      dt7.q    <= '0;
      dt7.zero <= tn6[TW-1] || (tn6 == '0);
      dt7.one  <= !($signed(tn6) < $signed(td6));
    end
  end

  // restoring divide, one quotient bit per stage
  logic [P-1:0] dv;
  geo_t         dg [P];
  div_t         ds [P];
  div_t         dt [P];

  for (genvar j = 0; j < P; j++) begin : g_div
    logic v_in;
    geo_t g_in;
    div_t s_in;
    div_t t_in;
    div_t s_nx;
    div_t t_nx;

    if (j == 0) begin : g_src
      assign v_in = v7;
      assign g_in = g7;
      assign s_in = ds7;
      assign t_in = dt7;
    end else begin : g_src
      assign v_in = dv[j-1];
      assign g_in = dg[j-1];
      assign s_in = ds[j-1];
      assign t_in = dt[j-1];
    end

    always_comb begin
      s_nx     = s_in;
      t_nx     = t_in;
      s_nx.rem = s_in.rem << 1;
      t_nx.rem = t_in.rem << 1;
      s_nx.q   = {s_in.q[P-2:0], 1'b0};
      t_nx.q   = {t_in.q[P-2:0], 1'b0};
      if (s_nx.rem >= s_in.den) begin
        s_nx.rem  = s_nx.rem - s_in.den;
        s_nx.q[0] = 1'b1;
      end
      if (t_nx.rem >= t_in.den) begin
        t_nx.rem  = t_nx.rem - t_in.den;
        t_nx.q[0] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else if (en) begin
        dv[j] <= v_in;
      end
      if (en) begin
        dg[j] <= g_in;
        ds[j] <= s_nx;
        dt[j] <= t_nx;
      end
    end
  end

  logic [PO-1:0] sq8;
  logic [PO-1:0] tq8;

  always_comb begin
    priority if (ds[P-1].zero) begin
      sq8 = '0;
    end else if (ds[P-1].one) begin
      sq8 = ONE;
    end else begin
      sq8 = {1'b0, ds[P-1].q};
    end
    priority if (dt[P-1].zero) begin
      tq8 = '0;
    end else if (dt[P-1].one) begin
      tq8 = ONE;
    end else begin
      tq8 = {1'b0, dt[P-1].q};
    end
  end

  // offsets of the closest points
  logic signed [DW-1:0]     m4_a [6];
  logic signed [SWB-1:0]    m4_b [6];
  logic signed [DW+SWB-1:0] m4_p [6];
  logic                     m4_v;
  fin_t                     m4_in;
  fin_t                     m4_f;

  always_comb begin
    m4_in.r  = dg[P-1].r;
    m4_in.sq = sq8;
    m4_in.tq = tq8;
    for (int k = 0; k < NA; k++) begin
      m4_a[k]   = $signed(dg[P-1].d1[k]);
      m4_b[k]   = $signed({1'b0, sq8});
      m4_a[3+k] = $signed(dg[P-1].d2[k]);
      m4_b[3+k] = $signed({1'b0, tq8});
    end
  end

  spcp_mul #(.N(6), .WA(DW), .WB(SWB), .WS($bits(fin_t))) u_mul_pt (
    .clk(clk), .rst(rst), .en(en), .vin(dv[P-1]), .a(m4_a), .b(m4_b), .side_in(m4_in),
    .vout(m4_v), .p(m4_p), .side_out(m4_f)
  );

  logic                 v9;
  logic signed [WW-1:0] w9 [NA];
  par_t                 pr9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= m4_v;
    end
    if (en) begin
      pr9.sq <= m4_f.sq;
      pr9.tq <= m4_f.tq;
      for (int k = 0; k < NA; k++) begin
        w9[k] <= (WW'($signed(m4_f.r[k])) <<< P) + WW'(m4_p[k]) - WW'(m4_p[3+k]);
      end
    end
  end

  // squared gap
  logic signed [2*WW-1:0] m5_p [NA];
  logic                   m5_v;
  par_t                   m5_r;

  spcp_mul #(.N(NA), .WA(WW), .WB(WW), .WS($bits(par_t))) u_mul_sq (
    .clk(clk), .rst(rst), .en(en), .vin(v9), .a(w9), .b(w9), .side_in(pr9),
    .vout(m5_v), .p(m5_p), .side_out(m5_r)
  );

  logic          v10;
  logic [SW-1:0] sum10;
  par_t          pr10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= m5_v;
    end
    if (en) begin
      pr10  <= m5_r;
      sum10 <= SW'(m5_p[0]) + SW'(m5_p[1]) + SW'(m5_p[2]);
    end
  end

  // integer square root, one root bit per stage
  logic [RB-1:0] rv;
  sqr_t          sr [RB];
  par_t          rp [RB];

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    logic          v_in;
    sqr_t          x_in;
    par_t          p_in;
    sqr_t          x_nx;
    logic [RB+1:0] trial;

    if (j == 0) begin : g_src
      assign v_in      = v10;
      assign x_in.rad  = sum10;
      assign x_in.rem  = '0;
      assign x_in.root = '0;
      assign p_in      = pr10;
    end else begin : g_src
      assign v_in = rv[j-1];
      assign x_in = sr[j-1];
      assign p_in = rp[j-1];
    end

    always_comb begin
      x_nx.rad  = x_in.rad << 2;
      x_nx.rem  = {x_in.rem[RB-1:0], x_in.rad[SW-1 -: 2]};
      trial     = {x_in.root, 2'b01};
      x_nx.root = {x_in.root[RB-2:0], 1'b0};
      if (x_nx.rem >= trial) begin
        x_nx.rem     = x_nx.rem - trial;
        x_nx.root[0] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[j] <= 1'b0;
      end else if (en) begin
        rv[j] <= v_in;
      end
      if (en) begin
        sr[j] <= x_nx;
        rp[j] <= p_in;
      end
    end
  end

  // output register
  logic [GW-1:0] gap;
  logic [PO-1:0] sq_out;
  logic [PO-1:0] tq_out;
  logic [GW-1:0] gap_next;

  always_comb begin
    if (|sr[RB-1].root[RB-1:P+GW]) begin
      gap_next = '1;
    end else begin
      gap_next = sr[RB-1].root[P +: GW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= rv[RB-1];
    end
    if (en) begin
      gap    <= gap_next;
      sq_out <= rp[RB-1].sq;
      tq_out <= rp[RB-1].tq;
    end
  end

  assign m_tdata = OW'({tq_out, sq_out, gap});

endmodule
